/* rtl/mts_pkg.sv */
// Shared constants and types for the max tracking stack.
// Depends on nothing; imported by max_tracking_stack and mts_checker.
package mts_pkg;

   localparam int DEPTH       = 1024;
   localparam int VALUE_WIDTH = 32;
   localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W     = $clog2(DEPTH + 1);

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [COUNT_W-1:0]            count_type;
   typedef logic [ADDR_W-1:0]             addr_type;

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   localparam count_type COUNT_FULL = COUNT_W'(DEPTH);

endpackage

/* rtl/mts_ram.sv */
// Simple dual-port synchronous RAM: one write port, one read port, read data registered.
// Stands alone; used for both stacks of the max tracking stack.
module mts_ram #(
   parameter int DATA_W = 32,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [0:(1 << ADDR_W)-1];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/max_tracking_stack.sv */
// Top level of the max tracking stack: depth counters, cached tops, two stack RAMs.
// Depends on mts_pkg and mts_ram.
//
//  channel   ports                                             handshake
//  request   req_kind, req_value                               start high while busy low
//  response  rsp_max_value, rsp_is_empty, rsp_entry_count,     rsp_strobe for one cycle
//            rsp_overflow
//
// For each word the accept cycle issues RAM writes and the refill read, and
// the next cycle (busy high) loads the new tops from the registered RAM read data.
// The response appears on the cycle after that; a new word may be accepted in it.
// Synchronous reset empties both stacks; RAM contents are not cleared.
// The receiver cannot stall; responses are never held back.
module max_tracking_stack
   import mts_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_kind,
   input  logic signed [31:0]     req_value,
   output logic                   rsp_strobe,
   output logic signed [31:0]     rsp_max_value,
   output logic                   rsp_is_empty,
   output logic [10:0]            rsp_entry_count,
   output logic                   rsp_overflow
);

   localparam logic PH_IDLE = 1'b0;
   localparam logic PH_LOAD = 1'b1;

   logic      phase_ff, phase_in;
   count_type vdepth_ff, vdepth_in;
   count_type mdepth_ff, mdepth_in;
   value_type vtop_ff, vtop_in;
   value_type mtop_ff, mtop_in;
   logic      vpop_ff, vpop_in;
   logic      mpop_ff, mpop_in;
   logic      ovf_ff, ovf_in;

   logic      rsp_strobe_ff, rsp_strobe_in;
   value_type rsp_max_ff, rsp_max_in;
   logic      rsp_empty_ff, rsp_empty_in;
   count_type rsp_count_ff, rsp_count_in;
   logic      rsp_ovf_ff, rsp_ovf_in;

   logic      accept;
   value_type push_value;
   logic      v_full;
   logic      m_take;
   logic      vram_we, mram_we;
   addr_type  vram_raddr, mram_raddr;
   value_type vram_rdata, mram_rdata;

   assign accept     = start & (phase_ff == PH_IDLE);
   assign push_value = value_type'(req_value);
   assign v_full     = (vdepth_ff == COUNT_FULL);
   assign m_take     = (mdepth_ff == '0) || (push_value >= mtop_ff);
   assign vram_we    = accept & (req_kind == KIND_PUSH) & ~v_full;
   assign mram_we    = vram_we & m_take & (mdepth_ff != COUNT_FULL);
   assign vram_raddr = ADDR_W'(vdepth_ff - count_type'(2));
   assign mram_raddr = ADDR_W'(mdepth_ff - count_type'(2));

   always_comb begin
      phase_in      = phase_ff;
      vdepth_in     = vdepth_ff;
      mdepth_in     = mdepth_ff;
      vtop_in       = vtop_ff;
      mtop_in       = mtop_ff;
      vpop_in       = vpop_ff;
      mpop_in       = mpop_ff;
      ovf_in        = ovf_ff;
      rsp_strobe_in = 1'b0;
      rsp_max_in    = rsp_max_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (accept) begin
               phase_in = PH_LOAD;
               vpop_in  = 1'b0;
               mpop_in  = 1'b0;
               ovf_in   = (req_kind == KIND_PUSH) & v_full;
               if (vram_we) begin
                  vdepth_in = vdepth_ff + count_type'(1);
                  vtop_in   = push_value;
               end
               if (mram_we) begin
                  mdepth_in = mdepth_ff + count_type'(1);
                  mtop_in   = push_value;
               end
               if ((req_kind == KIND_POP) && (vdepth_ff != '0)) begin
                  vpop_in   = 1'b1;
                  vdepth_in = vdepth_ff - count_type'(1);
                  if ((mdepth_ff != '0) && (mtop_ff == vtop_ff)) begin
                     mpop_in   = 1'b1;
                     mdepth_in = mdepth_ff - count_type'(1);
                  end
               end
            end
         end
         PH_LOAD: begin
            phase_in = PH_IDLE;
            if (vpop_ff) begin
               vtop_in = vram_rdata;
            end
            if (mpop_ff) begin
               mtop_in = mram_rdata;
            end
            rsp_strobe_in = 1'b1;
            rsp_max_in    = ((vdepth_ff == '0) || (mdepth_ff == '0)) ? '0 : mtop_in;
            rsp_empty_in  = (vdepth_ff == '0);
            rsp_count_in  = vdepth_ff;
            rsp_ovf_in    = ovf_ff;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         vdepth_ff     <= '0;
         mdepth_ff     <= '0;
         vpop_ff       <= 1'b0;
         mpop_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         vdepth_ff     <= vdepth_in;
         mdepth_ff     <= mdepth_in;
         vpop_ff       <= vpop_in;
         mpop_ff       <= mpop_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      vtop_ff      <= vtop_in;
      mtop_ff      <= mtop_in;
      ovf_ff       <= ovf_in;
      rsp_max_ff   <= rsp_max_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   mts_ram #(
      .DATA_W (VALUE_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (vram_we),
      .wr_addr (ADDR_W'(vdepth_ff)),
      .wr_data (push_value),
      .rd_addr (vram_raddr),
      .rd_data (vram_rdata)
   );

   mts_ram #(
      .DATA_W (VALUE_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_maxima_ram (
      .clock   (clock),
      .wr_en   (mram_we),
      .wr_addr (ADDR_W'(mdepth_ff)),
      .wr_data (push_value),
      .rd_addr (mram_raddr),
      .rd_data (mram_rdata)
   );

   assign busy            = (phase_ff == PH_LOAD);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_max_value   = 32'(rsp_max_ff);
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_entry_count = 11'(rsp_count_ff);
   assign rsp_overflow    = rsp_ovf_ff;

endmodule

/* rtl/mts_checker.sv */
// Port-level checks for the max tracking stack, bound to the top level.
// Depends on mts_pkg and max_tracking_stack.
module mts_checker
   import mts_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic signed [31:0] rsp_max_value,
   input logic               rsp_is_empty,
   input logic [10:0]        rsp_entry_count,
   input logic               rsp_overflow
);

   a_word_then_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("accepted word did not occupy the next cycle");

   a_word_then_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("response missing two cycles after accept");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_is_empty == (rsp_entry_count == 11'd0)))
      else $error("empty flag disagrees with entry count");

   a_empty_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_is_empty) |-> (rsp_max_value == 32'sd0))
      else $error("empty stack reports nonzero maximum");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_overflow) |-> (rsp_entry_count == 11'(DEPTH)))
      else $error("overflow flagged while stack not full");

endmodule

bind max_tracking_stack mts_checker u_mts_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_max_value   (rsp_max_value),
   .rsp_is_empty    (rsp_is_empty),
   .rsp_entry_count (rsp_entry_count),
   .rsp_overflow    (rsp_overflow)
);
